// ===== src/assert_macros.svh =====
// assertion macros for the tag frame parser top level
// expects i_clk and i_rst_n in the including scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition must hold at every clock edge out of reset
`define ID3_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// antecedent in one cycle implies consequent in the same cycle
`define ID3_ASSERT_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== src/id3_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the tag frame parser
// no dependencies
package id3_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic [1:0] field_kind;
        logic [7:0] value_byte;
        logic       has_byte;
        logic       last_of_value;
        logic       truncated;
    } t_out_item;

    localparam logic [0:0] CFG_MAX_VALUE_LEN = 1'd0;
    localparam logic [0:0] CFG_FIELD_ENABLE  = 1'd1;

    localparam logic [7:0] MAX_VALUE_LEN_RST = 8'd62;
    localparam logic [2:0] FIELD_ENABLE_RST  = 3'd7;

    localparam logic [1:0] KIND_TITLE  = 2'd0;
    localparam logic [1:0] KIND_ARTIST = 2'd1;
    localparam logic [1:0] KIND_ALBUM  = 2'd2;
    localparam logic [1:0] KIND_NONE   = 2'd3;

    localparam logic [7:0]  SIG_BYTE0 = 8'h49;
    localparam logic [7:0]  SIG_BYTE1 = 8'h44;
    localparam logic [7:0]  SIG_BYTE2 = 8'h33;
    localparam logic [6:0]  SYNCSAFE_MASK = 7'h7F;
    localparam logic [31:0] ID_TITLE  = 32'h5449_5432;
    localparam logic [31:0] ID_ARTIST = 32'h5450_4531;
    localparam logic [31:0] ID_ALBUM  = 32'h5441_4C42;

endpackage

// ===== src/id3v2_text_frame_extractor_top.sv =====
`timescale 1ns / 1ps
// top level: input register, parser, result register, configuration registers
// depends on id3_pkg, id3_parse and assert_macros.svh
//
// channel   direction  signals                             request
// input     in         i_in_valid, i_in_data, o_in_stall   one buffer byte
// output    out        o_out_valid, o_out_data, i_out_stall zero or one per byte
// config    in         i_cfg_we, i_cfg_index, i_cfg_data   register write
//
// one byte per cycle unless the output stalls; each result goes from r_in to r_out
// the parser state machine advances once per byte from the input register
// the input register holds one byte while a result waits on a stalled output
// reset is synchronous; the parser, valid flags and config registers get defaults
// a byte marked end of buffer returns the parser to its reset state
`include "assert_macros.svh"

module id3v2_text_frame_extractor_top import id3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  t_in_item   i_in_data,
    output logic       o_in_stall,
    output logic       o_out_valid,
    output t_out_item  o_out_data,
    input  logic       i_out_stall,
    input  logic       i_cfg_we,
    input  logic [0:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    logic       r_in_valid;
    t_in_item   r_in;
    logic       r_out_valid;
    t_out_item  r_out;
    logic [7:0] r_max_value_len;
    logic [2:0] r_field_enable;

    logic       advance;
    logic       res_valid;
    t_out_item  res;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    id3_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (advance),
        .i_item      (r_in),
        .i_max_len   (r_max_value_len),
        .i_enable    (r_field_enable),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_value_len <= MAX_VALUE_LEN_RST;
            r_field_enable  <= FIELD_ENABLE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_MAX_VALUE_LEN: r_max_value_len <= i_cfg_data;
                CFG_FIELD_ENABLE:  r_field_enable  <= i_cfg_data[2:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out <= res;
        end
    end

    `ID3_ASSERT_IMPLY(a_hold_on_stall, r_out_valid && i_out_stall && r_in_valid, o_in_stall, "input not held while output stalled")
    `ID3_ASSERT_IMPLY(a_marker_last, o_out_valid && !o_out_data.has_byte, o_out_data.last_of_value, "marker without last")
    `ID3_ASSERT_IMPLY(a_trunc_last, o_out_valid && o_out_data.truncated, o_out_data.last_of_value, "truncated without last")
    `ID3_ASSERT_ALWAYS(a_kind_range, !o_out_valid || o_out_data.field_kind != KIND_NONE, "bad field kind")

endmodule

// ===== src/id3_parse.sv =====
`timescale 1ns / 1ps
// per-byte tag and frame header state machine with value extraction
// depends on id3_pkg
module id3_parse import id3_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_step,
    input  t_in_item   i_item,
    input  logic [7:0] i_max_len,
    input  logic [2:0] i_enable,
    output logic       o_res_valid,
    output t_out_item  o_res
);

    localparam logic [2:0] PH_TAG_HDR   = 3'd0;
    localparam logic [2:0] PH_FRAME_HDR = 3'd1;
    localparam logic [2:0] PH_ENCODING  = 3'd2;
    localparam logic [2:0] PH_VALUE     = 3'd3;
    localparam logic [2:0] PH_SKIP      = 3'd4;
    localparam logic [2:0] PH_IDLE      = 3'd5;

    logic [2:0]  r_phase, n_phase;
    logic [3:0]  r_header_count, n_header_count;
    logic [27:0] r_tag_length, n_tag_length;
    logic [31:0] r_byte_offset, n_byte_offset;
    logic [31:0] r_frame_ident, n_frame_ident;
    logic [31:0] r_frame_length, n_frame_length;
    logic [3:0]  r_frame_header_count, n_frame_header_count;
    logic [31:0] r_bytes_left, n_bytes_left;
    logic [7:0]  r_value_count, n_value_count;
    logic [1:0]  r_current_kind, n_current_kind;

    logic [2:0]  ph;
    logic [7:0]  b;
    logic        eob;
    logic [1:0]  kind;
    logic        kind_en;
    logic [31:0] len_m1;
    logic [31:0] left_m1;
    logic [7:0]  count_m1;
    logic        sig_bad;

    assign b   = i_item.data_byte;
    assign eob = i_item.end_of_buffer;
    assign len_m1   = r_frame_length - 32'd1;
    assign left_m1  = r_bytes_left - 32'd1;
    assign count_m1 = r_value_count - 8'd1;

    always_comb begin
        case (r_frame_ident)
            ID_TITLE:  kind = KIND_TITLE;
            ID_ARTIST: kind = KIND_ARTIST;
            ID_ALBUM:  kind = KIND_ALBUM;
            default:   kind = KIND_NONE;
        endcase
        case (kind)
            KIND_TITLE:  kind_en = i_enable[0];
            KIND_ARTIST: kind_en = i_enable[1];
            KIND_ALBUM:  kind_en = i_enable[2];
            default:     kind_en = 1'b0;
        endcase
        sig_bad = (r_header_count == 4'd0 && b != SIG_BYTE0) ||
                  (r_header_count == 4'd1 && b != SIG_BYTE1) ||
                  (r_header_count == 4'd2 && b != SIG_BYTE2);
    end

    always_comb begin
        n_phase              = r_phase;
        n_header_count       = r_header_count;
        n_tag_length         = r_tag_length;
        n_byte_offset        = r_byte_offset;
        n_frame_ident        = r_frame_ident;
        n_frame_length       = r_frame_length;
        n_frame_header_count = r_frame_header_count;
        n_bytes_left         = r_bytes_left;
        n_value_count        = r_value_count;
        n_current_kind       = r_current_kind;
        o_res_valid          = 1'b0;
        o_res.field_kind     = r_current_kind;
        o_res.value_byte     = 8'd0;
        o_res.has_byte       = 1'b0;
        o_res.last_of_value  = 1'b1;
        o_res.truncated      = 1'b0;

        ph = r_phase;
        // tag end reached at a frame boundary
        if (r_phase == PH_FRAME_HDR && r_frame_header_count == 4'd0 &&
            r_byte_offset >= {4'd0, r_tag_length}) begin
            ph = PH_IDLE;
        end
        n_phase = ph;
        if (ph != PH_TAG_HDR && ph != PH_IDLE && r_byte_offset != '1) begin
            n_byte_offset = r_byte_offset + 32'd1;
        end

        case (ph)
            PH_TAG_HDR: begin
                if (sig_bad) begin
                    n_phase = PH_IDLE;
                end else begin
                    if (r_header_count >= 4'd6) begin
                        n_tag_length = {r_tag_length[20:0], b[6:0] & SYNCSAFE_MASK};
                    end
                    if (r_header_count >= 4'd9) begin
                        n_byte_offset        = 32'd0;
                        n_phase              = PH_FRAME_HDR;
                        n_frame_header_count = 4'd0;
                    end else begin
                        n_header_count = r_header_count + 4'd1;
                    end
                end
            end
            PH_FRAME_HDR: begin
                if (r_frame_header_count < 4'd4) begin
                    n_frame_ident = {r_frame_ident[23:0], b};
                end else if (r_frame_header_count < 4'd8) begin
                    n_frame_length = {r_frame_length[23:0], b};
                end
                if (r_frame_header_count >= 4'd9) begin
                    if (r_frame_length == 32'd0) begin
                        n_phase = PH_IDLE;
                    end else begin
                        if (kind != KIND_NONE) begin
                            n_current_kind = kind;
                        end
                        n_frame_header_count = 4'd0;
                        if (kind_en) begin
                            n_phase = PH_ENCODING;
                        end else begin
                            n_bytes_left = len_m1;
                            n_phase = (len_m1 == 32'd0) ? PH_FRAME_HDR : PH_SKIP;
                        end
                    end
                end else begin
                    n_frame_header_count = r_frame_header_count + 4'd1;
                end
            end
            PH_ENCODING: begin
                n_bytes_left  = len_m1;
                n_value_count = (r_frame_length <= {24'd0, i_max_len}) ?
                                len_m1[7:0] : i_max_len;
                if (n_value_count == 8'd0) begin
                    o_res_valid = 1'b1;
                end else if (eob) begin
                    o_res_valid     = 1'b1;
                    o_res.truncated = 1'b1;
                end
                if (len_m1 == 32'd0) begin
                    n_phase              = PH_FRAME_HDR;
                    n_frame_header_count = 4'd0;
                end else begin
                    n_phase = (n_value_count != 8'd0) ? PH_VALUE : PH_SKIP;
                end
            end
            PH_VALUE: begin
                n_bytes_left        = left_m1;
                n_value_count       = count_m1;
                o_res_valid         = 1'b1;
                o_res.value_byte    = b;
                o_res.has_byte      = 1'b1;
                o_res.last_of_value = (count_m1 == 8'd0) || eob;
                o_res.truncated     = eob && (count_m1 != 8'd0);
                if (left_m1 == 32'd0) begin
                    n_phase              = PH_FRAME_HDR;
                    n_frame_header_count = 4'd0;
                end else if (count_m1 == 8'd0) begin
                    n_phase = PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (r_bytes_left <= 32'd1) begin
                    n_bytes_left         = 32'd0;
                    n_phase              = PH_FRAME_HDR;
                    n_frame_header_count = 4'd0;
                end else begin
                    n_bytes_left = left_m1;
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step && eob)) begin
            r_phase              <= PH_TAG_HDR;
            r_header_count       <= 4'd0;
            r_tag_length         <= 28'd0;
            r_byte_offset        <= 32'd0;
            r_frame_ident        <= 32'd0;
            r_frame_length       <= 32'd0;
            r_frame_header_count <= 4'd0;
            r_bytes_left         <= 32'd0;
            r_value_count        <= 8'd0;
            r_current_kind       <= KIND_TITLE;
        end else if (i_step) begin
            r_phase              <= n_phase;
            r_header_count       <= n_header_count;
            r_tag_length         <= n_tag_length;
            r_byte_offset        <= n_byte_offset;
            r_frame_ident        <= n_frame_ident;
            r_frame_length       <= n_frame_length;
            r_frame_header_count <= n_frame_header_count;
            r_bytes_left         <= n_bytes_left;
            r_value_count        <= n_value_count;
            r_current_kind       <= n_current_kind;
        end
    end

endmodule
